[src/ecd_pkg.sv]
// ----------------------------------------------------------------------------
// ecd_pkg
// Shared constants and ring offset tables for the event corner detector.
// ----------------------------------------------------------------------------
package ecd_pkg;

  localparam int SENSOR_WIDTH_DEF  = 240;
  localparam int SENSOR_HEIGHT_DEF = 180;
  localparam int TIME_BITS_DEF     = 18;

  localparam int BORDER  = 4;
  localparam int INNER_N = 16;
  localparam int OUTER_N = 20;
  localparam int RING_N  = INNER_N + OUTER_N;
  localparam int IDX_W   = 6;

  // signed offset of ring point k (inner points first, then outer)
  function automatic logic signed [3:0] ring_dx(input logic [IDX_W-1:0] k);
    logic signed [3:0] d;
    case (k)
      6'd0: d = 0;   6'd1: d = 1;   6'd2: d = 2;   6'd3: d = 3;
      6'd4: d = 3;   6'd5: d = 3;   6'd6: d = 2;   6'd7: d = 1;
      6'd8: d = 0;   6'd9: d = -1;  6'd10: d = -2; 6'd11: d = -3;
      6'd12: d = -3; 6'd13: d = -3; 6'd14: d = -2; 6'd15: d = -1;
      6'd16: d = 0;  6'd17: d = 1;  6'd18: d = 2;  6'd19: d = 3;
      6'd20: d = 4;  6'd21: d = 4;  6'd22: d = 4;  6'd23: d = 3;
      6'd24: d = 2;  6'd25: d = 1;  6'd26: d = 0;  6'd27: d = -1;
      6'd28: d = -2; 6'd29: d = -3; 6'd30: d = -4; 6'd31: d = -4;
      6'd32: d = -4; 6'd33: d = -3; 6'd34: d = -2; 6'd35: d = -1;
      default: d = 0;
    endcase
    return d;
  endfunction

  function automatic logic signed [3:0] ring_dy(input logic [IDX_W-1:0] k);
    logic signed [3:0] d;
    case (k)
      6'd0: d = 3;   6'd1: d = 3;   6'd2: d = 2;   6'd3: d = 1;
      6'd4: d = 0;   6'd5: d = -1;  6'd6: d = -2;  6'd7: d = -3;
      6'd8: d = -3;  6'd9: d = -3;  6'd10: d = -2; 6'd11: d = -1;
      6'd12: d = 0;  6'd13: d = 1;  6'd14: d = 2;  6'd15: d = 3;
      6'd16: d = 4;  6'd17: d = 4;  6'd18: d = 3;  6'd19: d = 2;
      6'd20: d = 1;  6'd21: d = 0;  6'd22: d = -1; 6'd23: d = -2;
      6'd24: d = -3; 6'd25: d = -4; 6'd26: d = -4; 6'd27: d = -4;
      6'd28: d = -3; 6'd29: d = -2; 6'd30: d = -1; 6'd31: d = 0;
      6'd32: d = 1;  6'd33: d = 2;  6'd34: d = 3;  6'd35: d = 4;
      default: d = 0;
    endcase
    return d;
  endfunction

endpackage

[src/ecd_surface.sv]
// ----------------------------------------------------------------------------
// ecd_surface
// Active event surface: one-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module ecd_surface import ecd_pkg::*; #(
  parameter int DEPTH     = SENSOR_WIDTH_DEF * SENSOR_HEIGHT_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int ADDR_W    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_W-1:0]    addr,
  input  logic [TIME_BITS-1:0] wdata,
  output logic [TIME_BITS-1:0] rdata
);

  logic [TIME_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[src/ecd_ring_eval.sv]
// ----------------------------------------------------------------------------
// ecd_ring_eval
// Streak test over one ring held in a register file: one start point per
// cycle, all streak lengths of that start in parallel.
// ----------------------------------------------------------------------------
module ecd_ring_eval import ecd_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int N         = INNER_N,
  parameter int SMIN      = 3,
  parameter int SMAX      = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [TIME_BITS-1:0] v [N],
  output logic                 done,
  output logic                 pass
);

  localparam int SW = $clog2(N);

  logic          busy;
  logic [SW-1:0] pos;
  logic          hit;

  // fold a ring index below 2*N back onto the ring
  function automatic int wrap(input int a);
    return (a >= N) ? a - N : a;
  endfunction

  always_comb begin
    logic [TIME_BITS-1:0] lo;
    logic                 older;
    int                   p;
    hit = 1'b0;
    lo  = v[pos];
    for (int len = 1; len <= SMAX; len++) begin
      p = wrap(int'(pos) + len - 1);
      if (v[p] < lo) lo = v[p];
      if (len >= SMIN) begin
        older = 1'b1;
        for (int j = len; j < N; j++) begin
          if (v[wrap(int'(pos) + j)] >= lo) older = 1'b0;
        end
        if (v[pos] >= v[wrap(int'(pos) + N - 1)] &&
            v[p] >= v[wrap(int'(pos) + len)] && older) hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      pass <= 1'b0;
      pos  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        pos  <= '0;
        pass <= 1'b0;
      end else if (busy) begin
        if (hit) pass <= 1'b1;
        if (int'(pos) == N - 1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          pos <= pos + 1'b1;
        end
      end
    end
  end

endmodule

[src/event_corner_detector.sv]
// ----------------------------------------------------------------------------
// event_corner_detector
// Per-pixel timestamp surface with eFAST ring corner test.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one event per word: tdata = {event_time, event_y, event_x}
//   from the high bit down. m_axis returns one word per event, tdata[0] =
//   is_corner.
//   Events are handled one at a time. The surface RAM has one port, read
//   and written at one address per cycle; the up to 36 ring reads and the
//   ring tests set the rate. An inner event reads the 16 inner points,
//   hands them off, runs the inner ring test, then decides and loads the
//   result. When the inner ring qualifies, the 20 outer points are read,
//   handed off and tested in turn. Border and off-sensor events present
//   their result in the cycle after the input word is taken. The next input
//   word is taken the cycle after the result word leaves, so a receiver
//   stall also holds back the input.
//   After reset a clearing pass writes zero to every surface entry, one per
//   cycle (SENSOR_WIDTH*SENSOR_HEIGHT entries, 43200 by default); s_axis
//   tready stays low meanwhile.
//   A stalled m_axis holds the result; the next event is taken as soon as
//   the result register is free.
// ----------------------------------------------------------------------------
module event_corner_detector import ecd_pkg::*; #(
  parameter int SENSOR_WIDTH  = SENSOR_WIDTH_DEF,
  parameter int SENSOR_HEIGHT = SENSOR_HEIGHT_DEF,
  parameter int TIME_BITS     = TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // event_x[7:0], event_y[15:8], event_time[33:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // is_corner[0]
);

  localparam int DEPTH  = SENSOR_WIDTH * SENSOR_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]           state;
  logic [ADDR_W-1:0]    clr_addr;
  logic [7:0]           ev_x, ev_y;
  logic [IDX_W-1:0]     k;        // ring point being read
  logic                 rd_pend;  // read data arrives this cycle
  logic [IDX_W-1:0]     k_pend;
  logic                 outer;    // working on the outer ring
  logic [TIME_BITS-1:0] vin [INNER_N];
  logic [TIME_BITS-1:0] vout [OUTER_N];
  logic                 corner;
  logic                 res_valid;

  logic                 we;
  logic [ADDR_W-1:0]    addr;
  logic [TIME_BITS-1:0] wdata, rdata;
  logic                 in_start, in_done, in_pass, out_start, out_done, out_pass;

  logic [7:0]           tx, ty;
  logic [TIME_BITS-1:0] tt;
  logic                 accept;
  logic                 on_sensor, inside_border;
  logic signed [9:0]    px, py;

  assign tx = s_axis_tdata[7:0];
  assign ty = s_axis_tdata[15:8];
  assign tt = TIME_BITS'(s_axis_tdata[33:16]);
  assign s_axis_tready = (state == ST_IDLE) && !res_valid;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign on_sensor = (32'(tx) < SENSOR_WIDTH) && (32'(ty) < SENSOR_HEIGHT);
  assign inside_border = (32'(tx) >= BORDER) && (32'(tx) < SENSOR_WIDTH - BORDER) &&
                         (32'(ty) >= BORDER) && (32'(ty) < SENSOR_HEIGHT - BORDER);

  assign px = $signed({2'b00, ev_x}) + 10'(ring_dx(k));
  assign py = $signed({2'b00, ev_y}) + 10'(ring_dy(k));

  // column-major address, one multiply per address, fed straight to the RAM
  always_comb begin
    we    = 1'b0;
    wdata = tt;
    addr  = ADDR_W'(32'(px) * SENSOR_HEIGHT + 32'(py));
    if (state == ST_CLEAR) begin
      we    = 1'b1;
      wdata = '0;
      addr  = clr_addr;
    end else if (accept && on_sensor) begin
      we   = 1'b1;
      addr = ADDR_W'(32'(tx) * SENSOR_HEIGHT + 32'(ty));
    end
  end

  ecd_surface #(.DEPTH(DEPTH), .TIME_BITS(TIME_BITS), .ADDR_W(ADDR_W)) u_surface (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  ecd_ring_eval #(.TIME_BITS(TIME_BITS), .N(INNER_N), .SMIN(3), .SMAX(6)) u_inner (
    .clk(clk), .rst(rst), .start(in_start), .v(vin), .done(in_done), .pass(in_pass)
  );

  ecd_ring_eval #(.TIME_BITS(TIME_BITS), .N(OUTER_N), .SMIN(4), .SMAX(8)) u_outer (
    .clk(clk), .rst(rst), .start(out_start), .v(vout), .done(out_done), .pass(out_pass)
  );

  logic last_read;
  assign last_read = outer ? (k == IDX_W'(RING_N - 1)) : (k == IDX_W'(INNER_N - 1));
  assign in_start  = (state == ST_READ) && !outer && rd_pend && !last_read && 1'b0
                     || (state == ST_EVAL && !outer && rd_pend);
  assign out_start = (state == ST_EVAL && outer && rd_pend);

  // capture read data into the ring register files
  always_ff @(posedge clk) begin
    if (rd_pend) begin
      if (k_pend < IDX_W'(INNER_N)) vin[k_pend[3:0]] <= rdata;
      else vout[5'(k_pend - IDX_W'(INNER_N))] <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      res_valid <= 1'b0;
      rd_pend   <= 1'b0;
      corner    <= 1'b0;
      outer     <= 1'b0;
      k         <= '0;
    end else begin
      rd_pend <= 1'b0;
      k_pend  <= k;
      if (m_axis_tvalid && m_axis_tready) res_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          if (32'(clr_addr) == DEPTH - 1) state <= ST_IDLE;
          clr_addr <= clr_addr + 1'b1;
        end
        ST_IDLE: begin
          if (accept) begin
            ev_x  <= tx;
            ev_y  <= ty;
            k     <= '0;
            outer <= 1'b0;
            if (on_sensor && inside_border) begin
              state <= ST_READ;
            end else begin
              corner    <= 1'b0;
              res_valid <= 1'b1;
            end
          end
        end
        ST_READ: begin
          // issue one ring read a cycle
          rd_pend <= 1'b1;
          if (last_read) state <= ST_EVAL;
          else k <= k + 1'b1;
        end
        ST_EVAL: begin
          // last read data lands in the first cycle here; the evaluator start is raised in that same cycle
          if (!outer && in_done) begin
            if (in_pass) begin
              outer <= 1'b1;
              k     <= IDX_W'(INNER_N);
              state <= ST_READ;
            end else begin
              corner <= 1'b0;
              state  <= ST_DONE;
            end
          end else if (outer && out_done) begin
            corner <= out_pass;
            state  <= ST_DONE;
          end
        end
        ST_DONE: begin
          res_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {7'd0, corner};

`ifndef SYNTHESIS
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !s_axis_tready) else $error("accept during clear");
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ || state == ST_EVAL) |-> !we) else $error("write during ring read");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
`endif

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives camera events into event_corner_detector over the input stream and
// checks every is_corner word against a value typed into the directed table
// or an in-bench model of the timestamp surface and of the two ring tests.
// A short directed table comes first. Random events follow, mostly bursts
// built around a chosen center so that real corners show up. Both stream
// sides idle at random, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module testbench;
  import ecd_pkg::*;

  localparam int WIDTH   = 240;
  localparam int HEIGHT  = 180;
  localparam int TW      = 18;
  localparam int N_RANDOM = 1030;
  localparam longint CYCLE_LIMIT = 4000000;

  // Ring offsets, inner 16 points at radius 3, outer 20 points at radius 4.
  localparam int IN_DX [16] = '{0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1};
  localparam int IN_DY [16] = '{3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1, 0, 1, 2, 3};
  localparam int OUT_DX [20] = '{0, 1, 2, 3, 4, 4, 4, 3, 2, 1,
                                 0, -1, -2, -3, -4, -4, -4, -3, -2, -1};
  localparam int OUT_DY [20] = '{4, 4, 3, 2, 1, 0, -1, -2, -3, -4,
                                 -4, -4, -3, -2, -1, 0, 1, 2, 3, 4};

  typedef struct {
    logic [7:0]    x;
    logic [7:0]    y;
    logic [TW-1:0] t;
    bit            known;   // expected value typed in below
    bit            corner;
  } event_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;

  logic [TW-1:0] surface [0:WIDTH*HEIGHT-1];
  bit            corner_queue [$];
  int            send_idle;
  int            recv_idle;
  bit            hold_req;
  int            errors;
  longint        cycles;

  event_corner_detector uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Directed events: extremes, off-sensor, every border side, wrap of time.
  event_row_t directed [] = '{
    '{8'd0,   8'd0,   18'h00000, 1, 0},  // corner pixel, zero time
    '{8'd239, 8'd179, 18'h3FFFF, 1, 0},  // far corner, max time
    '{8'd255, 8'd255, 18'h3FFFF, 1, 0},  // off sensor, all ones
    '{8'd240, 8'd90,  18'h2AAAA, 1, 0},  // column just off sensor
    '{8'd120, 8'd180, 18'h15555, 1, 0},  // row just off sensor
    '{8'd3,   8'd90,  18'h00010, 1, 0},  // left border band
    '{8'd236, 8'd90,  18'h00011, 1, 0},  // right border band
    '{8'd120, 8'd3,   18'h00012, 1, 0},  // top border band
    '{8'd120, 8'd176, 18'h00013, 1, 0},  // bottom border band
    '{8'd100, 8'd100, 18'h00020, 1, 0},  // flat zero neighborhood
    '{8'd4,   8'd4,   18'h3FFFF, 0, 0},  // first inner pixel
    '{8'd235, 8'd175, 18'h3FFFF, 0, 0},  // last inner pixel
    '{8'hAA,  8'h55,  18'h2AAAA, 0, 0},
    '{8'h55,  8'hAA,  18'h15555, 0, 0},
    // streak pattern around (60,60): newer streak on the right side
    '{8'd63,  8'd61,  18'h3FFF0, 0, 0},
    '{8'd63,  8'd60,  18'h3FFF1, 0, 0},
    '{8'd63,  8'd59,  18'h3FFF2, 0, 0},
    '{8'd64,  8'd61,  18'h3FFF3, 0, 0},
    '{8'd64,  8'd60,  18'h3FFF4, 0, 0},
    '{8'd64,  8'd59,  18'h3FFF5, 0, 0},
    '{8'd64,  8'd58,  18'h3FFF6, 0, 0},
    '{8'd60,  8'd60,  18'h3FFFF, 0, 0},
    // time wraps to a small value: the new point now looks older than the rest of the streak
    '{8'd64,  8'd60,  18'h00001, 0, 0},
    '{8'd60,  8'd60,  18'h00002, 0, 0}
  };

  function automatic bit streak_found(input logic [TW-1:0] pts [20], input int n,
                                      input int smin, input int smax);
    logic [TW-1:0] lo;
    bit            older;
    for (int s = 0; s < n; s++) begin
      for (int len = smin; len <= smax; len++) begin
        if (pts[s] < pts[(s + n - 1) % n]) continue;
        if (pts[(s + len - 1) % n] < pts[(s + len) % n]) continue;
        lo = pts[s];
        for (int j = 1; j < len; j++)
          if (pts[(s + j) % n] < lo) lo = pts[(s + j) % n];
        older = 1;
        for (int j = len; j < n; j++)
          if (pts[(s + j) % n] >= lo) older = 0;
        if (older) return 1;
      end
    end
    return 0;
  endfunction

  // Store the timestamp, then run both ring tests on the updated surface.
  function automatic bit corner_of(input logic [7:0] x, input logic [7:0] y,
                                   input logic [TW-1:0] t);
    logic [TW-1:0] pts [20];
    int xi;
    int yi;
    xi = int'(x);
    yi = int'(y);
    if (xi >= WIDTH || yi >= HEIGHT) return 0;
    surface[xi*HEIGHT + yi] = t;
    if (xi < BORDER || xi >= WIDTH - BORDER || yi < BORDER || yi >= HEIGHT - BORDER)
      return 0;
    for (int k = 0; k < 16; k++) pts[k] = surface[(xi + IN_DX[k])*HEIGHT + yi + IN_DY[k]];
    for (int k = 16; k < 20; k++) pts[k] = '0;
    if (!streak_found(pts, 16, 3, 6)) return 0;
    for (int k = 0; k < 20; k++) pts[k] = surface[(xi + OUT_DX[k])*HEIGHT + yi + OUT_DY[k]];
    return streak_found(pts, 20, 4, 8);
  endfunction

  // Offer one event word, then hold until it is taken.
  task automatic push_event(input logic [7:0] x, input logic [7:0] y,
                            input logic [TW-1:0] t, input bit known, input bit want);
    bit predicted;
    @(negedge clk);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, t, y, x};
    do @(posedge clk); while (!s_axis_tready);
    predicted = corner_of(x, y, t);
    corner_queue.push_back(known ? want : predicted);
  endtask

  // Old times on both rings, a newer arc on each, then the center event.
  task automatic corner_burst(output int pushed);
    int cx;
    int cy;
    int s_in;
    int l_in;
    int s_out;
    int l_out;
    logic [TW-1:0] base;
    cx = $urandom_range(WIDTH - 5, 4);
    cy = $urandom_range(HEIGHT - 5, 4);
    base = TW'($urandom);
    s_in = $urandom_range(15);
    l_in = $urandom_range(7, 2);
    s_out = (s_in * 20) / 16 + $urandom_range(1);
    l_out = $urandom_range(9, 3);
    pushed = 16 + 20 + l_in + l_out + 1;
    for (int k = 0; k < 16; k++)
      push_event(8'(cx + IN_DX[k]), 8'(cy + IN_DY[k]),
                 TW'(base - $urandom_range(2000, 1)), 0, 0);
    for (int k = 0; k < 20; k++)
      push_event(8'(cx + OUT_DX[k]), 8'(cy + OUT_DY[k]),
                 TW'(base - $urandom_range(2000, 1)), 0, 0);
    for (int j = 0; j < l_in; j++) begin
      int k;
      k = (s_in + j) % 16;
      push_event(8'(cx + IN_DX[k]), 8'(cy + IN_DY[k]),
                 TW'(base + j + $urandom_range(3)), 0, 0);
    end
    for (int j = 0; j < l_out; j++) begin
      int k;
      k = (s_out + j) % 20;
      push_event(8'(cx + OUT_DX[k]), 8'(cy + OUT_DY[k]),
                 TW'(base + j + $urandom_range(3)), 0, 0);
    end
    push_event(8'(cx), 8'(cy), TW'(base + 50), 0, 0);
  endtask

  // Random receiver stalls, with one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        m_axis_tready <= 1'b0;
        repeat (500) @(negedge clk);
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Check each result word against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (corner_queue.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual is_corner=%0b",
                 $time, m_axis_tdata[0]);
        errors++;
      end else begin
        bit want;
        want = corner_queue.pop_front();
        if (m_axis_tdata[0] !== want) begin
          $display("%0t: is_corner mismatch, expected %0b, actual %0b",
                   $time, want, m_axis_tdata[0]);
          errors++;
        end
      end
    end
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int sent;
    int phase_len;
    int pushed;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    errors        = 0;
    cycles        = 0;
    hold_req      = 0;
    send_idle     = 15;
    recv_idle     = 56;
    for (int i = 0; i < WIDTH*HEIGHT; i++) surface[i] = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    foreach (directed[i])
      push_event(directed[i].x, directed[i].y, directed[i].t,
                 directed[i].known, directed[i].corner);

    // Back the block up while events keep coming.
    hold_req = 1;
    sent = 0;
    phase_len = N_RANDOM / 3;
    while (sent < N_RANDOM) begin
      if (sent >= 2*phase_len) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (sent >= phase_len) begin
        send_idle = 56;
        recv_idle = 15;
      end
      if ($urandom_range(99) < 60) begin
        corner_burst(pushed);
        sent += pushed;
      end else begin
        case ($urandom_range(3))
          0: push_event(8'($urandom), 8'($urandom), TW'($urandom), 0, 0);
          1: push_event(8'($urandom_range(WIDTH - 1)), 8'($urandom_range(HEIGHT - 1)),
                        TW'($urandom), 0, 0);
          default: push_event(8'($urandom_range(WIDTH - 5, 4)),
                              8'($urandom_range(HEIGHT - 5, 4)), TW'($urandom), 0, 0);
        endcase
        sent++;
      end
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b0;

    while (corner_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
